FILE: rtl/c8ic_pkg.sv
package c8ic_pkg;

  localparam logic [11:0] PC_RESET = 12'h200;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_EXEC  = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_REG   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_OVER  = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MRD,
    S_F0,
    S_F1,
    S_F2,
    S_EXEC,
    S_POP,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WAIT,
    S_LOAD_WR,
    S_OUT
  } state_t;

  localparam logic [7:0] KK_GET_DT = 8'h07;
  localparam logic [7:0] KK_SET_DT = 8'h15;
  localparam logic [7:0] KK_SET_ST = 8'h18;
  localparam logic [7:0] KK_ADD_I  = 8'h1E;
  localparam logic [7:0] KK_BCD    = 8'h33;
  localparam logic [7:0] KK_STORE  = 8'h55;
  localparam logic [7:0] KK_LOAD   = 8'h65;

  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
    logic [7:0] h;
    logic [7:0] r;
    logic [7:0] t;
    logic [7:0] res;
    begin
      h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
      r = v - h * 8'd100;
      t = 8'((16'(r) * 16'd205) >> 11);
      case (k)
        2'd0: res = h;
        2'd1: res = t;
        default: res = r - t * 8'd10;
      endcase
      return res;
    end
  endfunction

endpackage

FILE: rtl/c8ic_mem.sv
module c8ic_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [11:0] waddr,
  input  logic [7:0]  wdata,
  input  logic [11:0] raddr,
  output logic [7:0]  rdata
);
  logic [7:0] mem [0:4095];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/chip8_instruction_core.sv
// CHIP-8 instruction core. After reset the block clears its 4096-byte memory,
// one byte per cycle, and accepts no item until that is done. Each item then
// takes one action. Fx33, Fx55 and Fx65 move one byte per access, since the
// memory has one write port and one read port with a registered read, so Fx65
// reads, waits for and writes back each byte in turn.
module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [11:0] in_addr,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_data,
  output logic [11:0] out_pc_now,
  output logic [15:0] out_index_now,
  output logic        out_sound_on
);
  import c8ic_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [11:0] clr_r, clr_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [15:0] ins_r, ins_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  dt_r, dt_nxt;
  logic [7:0]  st_r, st_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic [7:0]  v_r [0:15];
  logic [11:0] stk_r [0:STACK_DEPTH-1];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [7:0]  rd_r, rd_nxt;

  logic        v_we;
  logic [3:0]  v_wa;
  logic [7:0]  v_wd;
  logic        f_we;
  logic        f_wd;
  logic        s_we;
  logic [11:0] s_wd;

  logic        m_we;
  logic [11:0] m_wa, m_ra;
  logic [7:0]  m_wd, m_rd;

  c8ic_mem u_mem (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, pc2, pc4;
  logic [8:0]  sum9;
  logic [SPW-1:0] dtop;

  always_comb begin
    x   = ins_r[11:8];
    y   = ins_r[7:4];
    n   = ins_r[3:0];
    kk  = ins_r[7:0];
    nnn = ins_r[11:0];
    vx  = v_r[x];
    vy  = v_r[y];
    pc2 = pc_r + 12'd2;
    pc4 = pc_r + 12'd4;
    sum9 = {1'b0, vx} + {1'b0, vy};
    dtop = SPW'(dep_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == 12'hFFF) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_READ: state_nxt = S_MRD;
            ACT_EXEC: state_nxt = S_F0;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_MRD: state_nxt = S_OUT;
      S_F0:  state_nxt = S_F1;
      S_F1:  state_nxt = S_F2;
      S_F2:  state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_OUT;
        if (ins_r == 16'h00EE && dep_r != '0) state_nxt = S_POP;
        if (ins_r[15:12] == 4'hF) begin
          if (kk == KK_BCD) state_nxt = S_BCD;
          if (kk == KK_STORE) state_nxt = S_STORE;
          if (kk == KK_LOAD) state_nxt = S_LOAD_RD;
        end
      end
      S_POP: state_nxt = S_OUT;
      S_BCD: if (cnt_r == 4'd2) state_nxt = S_OUT;
      S_STORE: if (cnt_r == x) state_nxt = S_OUT;
      S_LOAD_RD: state_nxt = S_LOAD_WAIT;
      S_LOAD_WAIT: state_nxt = S_LOAD_WR;
      S_LOAD_WR: state_nxt = (cnt_r == x) ? S_OUT : S_LOAD_RD;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt = clr_r + 12'd1;
    act_nxt = act_r;  addr_nxt = addr_r;  data_nxt = data_r;  rnd_nxt = rnd_r;
    ins_nxt = ins_r;  pc_nxt = pc_r;      idx_nxt = idx_r;
    dt_nxt = dt_r;    st_nxt = st_r;      dep_nxt = dep_r;
    cnt_nxt = cnt_r;  stat_nxt = stat_r;  rd_nxt = rd_r;
    v_we = 1'b0; v_wa = x; v_wd = 8'd0; f_we = 1'b0; f_wd = 1'b0;
    s_we = 1'b0; s_wd = pc2;
    m_we = 1'b0; m_wa = addr_r; m_wd = data_r; m_ra = addr_r;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        m_we = 1'b1; m_wa = clr_r; m_wd = 8'd0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        m_ra = in_addr;
        if (in_valid) begin
          act_nxt = in_action; addr_nxt = in_addr; data_nxt = in_data;
          rnd_nxt = in_random_byte;
          stat_nxt = ST_OK; rd_nxt = 8'd0; cnt_nxt = 4'd0;
          case (in_action)
            ACT_WRITE: begin
              m_we = 1'b1; m_wa = in_addr; m_wd = in_data;
            end
            ACT_TICK: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
              if (st_r != 8'd0) st_nxt = st_r - 8'd1;
            end
            ACT_REG: rd_nxt = v_r[in_addr[3:0]];
            default: ;
          endcase
        end
      end
      S_MRD: rd_nxt = m_rd;
      S_F0: m_ra = pc_r;
      S_F1: begin
        m_ra = pc_r + 12'd1;
        ins_nxt[15:8] = m_rd;
      end
      S_F2: ins_nxt[7:0] = m_rd;
      S_EXEC: begin
        pc_nxt = pc2;
        case (ins_r[15:12])
          4'h0: begin
            if (ins_r != 16'h00EE) stat_nxt = ST_UNSUP;
            else if (dep_r == '0) stat_nxt = ST_UNDER;
            else dep_nxt = dep_r - DW'(1);
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (dep_r >= DW'(STACK_DEPTH)) stat_nxt = ST_OVER;
            else begin
              s_we = 1'b1; s_wd = pc2;
              dep_nxt = dep_r + DW'(1);
              pc_nxt = nnn;
            end
          end
          4'h3: if (vx == kk) pc_nxt = pc4;
          4'h4: if (vx != kk) pc_nxt = pc4;
          4'h5: begin
            if (n != 4'd0) stat_nxt = ST_UNSUP;
            else if (vx == vy) pc_nxt = pc4;
          end
          4'h6: begin v_we = 1'b1; v_wd = kk; end
          4'h7: begin v_we = 1'b1; v_wd = vx + kk; end
          4'h8: begin
            case (n)
              4'h0: begin v_we = 1'b1; v_wd = vy; end
              4'h1: begin v_we = 1'b1; v_wd = vx | vy; end
              4'h2: begin v_we = 1'b1; v_wd = vx & vy; end
              4'h3: begin v_we = 1'b1; v_wd = vx ^ vy; end
              4'h4: begin
                v_we = 1'b1; v_wd = sum9[7:0]; f_we = 1'b1; f_wd = sum9[8];
              end
              4'h5: begin
                v_we = 1'b1; v_wd = vx - vy; f_we = 1'b1; f_wd = (vx >= vy);
              end
              4'h6: begin
                v_we = 1'b1; v_wd = {1'b0, vx[7:1]}; f_we = 1'b1; f_wd = vx[0];
              end
              4'h7: begin
                v_we = 1'b1; v_wd = vy - vx; f_we = 1'b1; f_wd = (vy >= vx);
              end
              4'hE: begin
                v_we = 1'b1; v_wd = {vx[6:0], 1'b0}; f_we = 1'b1; f_wd = vx[7];
              end
              default: stat_nxt = ST_UNSUP;
            endcase
          end
          4'h9: begin
            if (n != 4'd0) stat_nxt = ST_UNSUP;
            else if (vx != vy) pc_nxt = pc4;
          end
          4'hA: idx_nxt = {4'd0, nnn};
          4'hB: pc_nxt = nnn + {4'd0, v_r[0]};
          4'hC: begin v_we = 1'b1; v_wd = rnd_r & kk; end
          4'hF: begin
            case (kk)
              KK_GET_DT: begin v_we = 1'b1; v_wd = dt_r; end
              KK_SET_DT: dt_nxt = vx;
              KK_SET_ST: st_nxt = vx;
              KK_ADD_I:  idx_nxt = idx_r + {8'd0, vx};
              KK_BCD, KK_STORE, KK_LOAD: ;
              default: stat_nxt = ST_UNSUP;
            endcase
          end
          default: stat_nxt = ST_UNSUP;
        endcase
      end
      S_POP: pc_nxt = stk_r[dtop];
      S_BCD: begin
        m_we = 1'b1;
        m_wa = idx_r[11:0] + {8'd0, cnt_r};
        m_wd = bcd_digit(vx, cnt_r[1:0]);
        cnt_nxt = cnt_r + 4'd1;
      end
      S_STORE: begin
        m_we = 1'b1;
        m_wa = idx_r[11:0] + {8'd0, cnt_r};
        m_wd = v_r[cnt_r];
        cnt_nxt = cnt_r + 4'd1;
      end
      S_LOAD_RD: m_ra = idx_r[11:0] + {8'd0, cnt_r};
      S_LOAD_WAIT: m_ra = idx_r[11:0] + {8'd0, cnt_r};
      S_LOAD_WR: begin
        v_we = 1'b1; v_wa = cnt_r; v_wd = m_rd;
        cnt_nxt = cnt_r + 4'd1;
      end
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= 12'd0;
      pc_r    <= PC_RESET;
      idx_r   <= 16'd0;
      dt_r    <= 8'd0;
      st_r    <= 8'd0;
      dep_r   <= '0;
      for (int i = 0; i < 16; i++) v_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      idx_r   <= idx_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      dep_r   <= dep_nxt;
      if (v_we && !(f_we && v_wa == 4'hF)) v_r[v_wa] <= v_wd;
      if (f_we) v_r[15] <= {7'd0, f_wd};
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    rnd_r  <= rnd_nxt;
    ins_r  <= ins_nxt;
    cnt_r  <= cnt_nxt;
    stat_r <= stat_nxt;
    rd_r   <= rd_nxt;
    if (s_we) stk_r[dtop] <= s_wd;
  end

  assign out_status    = stat_r;
  assign out_read_data = (act_r == ACT_READ || act_r == ACT_REG) ? rd_r : 8'd0;
  assign out_pc_now    = pc_r;
  assign out_index_now = idx_r;
  assign out_sound_on  = (st_r != 8'd0);
endmodule

FILE: tb/sv/chip8_instruction_core_tb.sv
`timescale 1ns / 1ps

module chip8_instruction_core_tb;
  import c8ic_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t     status;
    logic [7:0]  read_data;
    logic [11:0] pc_now;
    logic [15:0] index_now;
    logic        sound_on;
  } outcome_t;

  typedef struct {
    logic [2:0]  action;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  rnd;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [11:0] in_addr;
  logic [7:0]  in_data;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [7:0]  out_read_data;
  logic [11:0] out_pc_now;
  logic [15:0] out_index_now;
  logic        out_sound_on;

  logic [7:0]  ram [4096];
  logic [7:0]  vreg [16];
  logic [15:0] idx_reg;
  logic [11:0] pc_reg;
  logic [11:0] call_stk [STACK_DEPTH];
  int          call_depth;
  logic [7:0]  delay_t;
  logic [7:0]  sound_t;

  outcome_t pending_results[$];
  row_t     dir_rows[$];
  int       mismatches;
  int       cycles;
  bit       calm;

  chip8_instruction_core #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_addr(in_addr), .in_data(in_data), .in_random_byte(in_random_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_read_data(out_read_data), .out_pc_now(out_pc_now),
    .out_index_now(out_index_now), .out_sound_on(out_sound_on)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic status_t run_instruction(input logic [7:0] rnd);
    logic [15:0] ins;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, r;
    logic [11:0] nnn, npc;
    logic [8:0]  sum;
    logic        f;
    status_t     st;
    bit          flagged;
    ins = {ram[pc_reg], ram[pc_reg + 12'd1]};
    x = ins[11:8];
    y = ins[7:4];
    n = ins[3:0];
    kk = ins[7:0];
    nnn = ins[11:0];
    npc = pc_reg + 12'd2;
    st = ST_OK;
    vx = vreg[x];
    vy = vreg[y];
    case (ins[15:12])
      4'h0: begin
        if (ins != 16'h00EE) st = ST_UNSUP;
        else if (call_depth == 0) st = ST_UNDER;
        else begin
          call_depth--;
          npc = call_stk[call_depth];
        end
      end
      4'h1: npc = nnn;
      4'h2: begin
        if (call_depth >= STACK_DEPTH) st = ST_OVER;
        else begin
          call_stk[call_depth] = npc;
          call_depth++;
          npc = nnn;
        end
      end
      4'h3: if (vx == kk) npc = npc + 12'd2;
      4'h4: if (vx != kk) npc = npc + 12'd2;
      4'h5: if (n != 4'h0) st = ST_UNSUP; else if (vx == vy) npc = npc + 12'd2;
      4'h6: vreg[x] = kk;
      4'h7: vreg[x] = vx + kk;
      4'h8: begin
        flagged = 1'b1;
        r = 8'h00;
        f = 1'b0;
        case (n)
          4'h0: begin vreg[x] = vy; flagged = 1'b0; end
          4'h1: begin vreg[x] = vx | vy; flagged = 1'b0; end
          4'h2: begin vreg[x] = vx & vy; flagged = 1'b0; end
          4'h3: begin vreg[x] = vx ^ vy; flagged = 1'b0; end
          4'h4: begin sum = {1'b0, vx} + {1'b0, vy}; r = sum[7:0]; f = sum[8]; end
          4'h5: begin r = vx - vy; f = (vx >= vy); end
          4'h6: begin r = vx >> 1; f = vx[0]; end
          4'h7: begin r = vy - vx; f = (vy >= vx); end
          4'hE: begin r = vx << 1; f = vx[7]; end
          default: begin st = ST_UNSUP; flagged = 1'b0; end
        endcase
        if (flagged) begin
          vreg[x] = r;
          vreg[15] = {7'd0, f};
        end
      end
      4'h9: if (n != 4'h0) st = ST_UNSUP; else if (vx != vy) npc = npc + 12'd2;
      4'hA: idx_reg = {4'h0, nnn};
      4'hB: npc = nnn + {4'h0, vreg[0]};
      4'hC: vreg[x] = rnd & kk;
      4'hF: begin
        case (kk)
          KK_GET_DT: vreg[x] = delay_t;
          KK_SET_DT: delay_t = vx;
          KK_SET_ST: sound_t = vx;
          KK_ADD_I:  idx_reg = idx_reg + {8'h00, vx};
          KK_BCD: begin
            ram[idx_reg[11:0]] = vx / 100;
            ram[idx_reg[11:0] + 12'd1] = (vx / 10) % 10;
            ram[idx_reg[11:0] + 12'd2] = vx % 10;
          end
          KK_STORE: for (int i = 0; i <= x; i++) ram[idx_reg[11:0] + 12'(i)] = vreg[i];
          KK_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = ram[idx_reg[11:0] + 12'(i)];
          default: st = ST_UNSUP;
        endcase
      end
      default: st = ST_UNSUP;
    endcase
    pc_reg = npc;
    return st;
  endfunction

  function automatic outcome_t chip8_step(input logic [2:0] action, input logic [11:0] addr,
                                          input logic [7:0] data, input logic [7:0] rnd);
    outcome_t o;
    o.status = ST_OK;
    o.read_data = 8'h00;
    case (action)
      ACT_WRITE: ram[addr] = data;
      ACT_READ:  o.read_data = ram[addr];
      ACT_EXEC:  o.status = run_instruction(rnd);
      ACT_TICK: begin
        if (delay_t != 8'h00) delay_t--;
        if (sound_t != 8'h00) sound_t--;
      end
      ACT_REG:   o.read_data = vreg[addr[3:0]];
      default: ;
    endcase
    o.pc_now = pc_reg;
    o.index_now = idx_reg;
    o.sound_on = (sound_t != 8'h00);
    return o;
  endfunction

  task automatic send(input logic [2:0] action, input logic [11:0] addr, input logic [7:0] data,
                      input logic [7:0] rnd, input bit typed, input outcome_t want);
    int gap;
    outcome_t got;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_addr <= addr;
    in_data <= data;
    in_random_byte <= rnd;
    do @(posedge clk); while (in_stall);
    got = chip8_step(action, addr, data, rnd);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic send_plain(input logic [2:0] action, input logic [11:0] addr,
                            input logic [7:0] data, input logic [7:0] rnd);
    outcome_t none;
    none = '{ST_OK, 8'h00, 12'h000, 16'h0000, 1'b0};
    send(action, addr, data, rnd, 1'b0, none);
  endtask

  function automatic row_t mk(input logic [2:0] action, input logic [11:0] addr,
                              input logic [7:0] data, input bit typed, input status_t st,
                              input logic [7:0] rd, input logic [11:0] pc);
    row_t r;
    r.action = action;
    r.addr = addr;
    r.data = data;
    r.rnd = 8'hAA;
    r.typed = typed;
    r.want = '{st, rd, pc, 16'h0000, 1'b0};
    return r;
  endfunction

  function automatic logic [15:0] pick_instruction(input bit call_heavy);
    logic [15:0] ins;
    logic [7:0]  fk [7];
    fk = '{KK_GET_DT, KK_SET_DT, KK_SET_ST, KK_ADD_I, KK_BCD, KK_STORE, KK_LOAD};
    ins = 16'($urandom);
    if (call_heavy && $urandom_range(0, 2) == 0) ins[15:12] = 4'h2;
    case (ins[15:12])
      4'h0: if ($urandom_range(0, 3) != 0) ins = 16'h00EE;
      4'h5, 4'h9: if ($urandom_range(0, 3) != 0) ins[3:0] = 4'h0;
      4'h8: if ($urandom_range(0, 4) != 0) ins[3:0] = 4'($urandom_range(0, 8)) == 4'h8
                                                        ? 4'hE : 4'($urandom_range(0, 7));
      4'hF: if ($urandom_range(0, 4) != 0) ins[7:0] = fk[$urandom_range(0, 6)];
      default: ;
    endcase
    return ins;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_read_data !== e.read_data) report("read_data", out_read_data, e.read_data);
        if (out_pc_now !== e.pc_now) report("pc_now", out_pc_now, e.pc_now);
        if (out_index_now !== e.index_now) report("index_now", out_index_now, e.index_now);
        if (out_sound_on !== e.sound_on) report("sound_on", out_sound_on, e.sound_on);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("chip8_instruction_core_tb failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    logic [15:0] ins;
    row_t r;
    int k;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_READ;
    in_addr = 12'h000;
    in_data = 8'h00;
    in_random_byte = 8'h00;
    foreach (ram[i]) ram[i] = 8'h00;
    foreach (vreg[i]) vreg[i] = 8'h00;
    foreach (call_stk[i]) call_stk[i] = 12'h000;
    idx_reg = 16'h0000;
    pc_reg = PC_RESET;
    call_depth = 0;
    delay_t = 8'h00;
    sound_t = 8'h00;

    dir_rows.push_back(mk(ACT_READ, 12'hFFF, 8'hFF, 1, ST_OK, 8'h00, PC_RESET));
    dir_rows.push_back(mk(ACT_REG, 12'h00F, 8'h00, 1, ST_OK, 8'h00, PC_RESET));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 1, ST_UNSUP, 8'h00, 12'h202));
    dir_rows.push_back(mk(ACT_WRITE, 12'h202, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h203, 8'hEE, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 1, ST_UNDER, 8'h00, 12'h204));
    dir_rows.push_back(mk(ACT_WRITE, 12'h204, 8'h6F, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h205, 8'hFF, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h206, 8'h8F, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h207, 8'hFE, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h208, 8'hFF, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h209, 8'h18, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_TICK, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h20A, 8'hAF, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h20B, 8'hFF, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h20C, 8'h2F, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_WRITE, 12'h20D, 8'hFE, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(ACT_EXEC, 12'h000, 8'h00, 0, ST_OK, 8'h00, 12'h0));
    dir_rows.push_back(mk(3'd7, 12'hFFF, 8'hFF, 0, ST_OK, 8'h00, 12'h0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      r.want.index_now = idx_reg;
      send(r.action, r.addr, r.data, r.rnd, r.typed, r.want);
    end

    k = 0;
    while (k < 900) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        ins = pick_instruction(((k / 150) % 2) == 1);
        send_plain(ACT_WRITE, pc_reg, ins[15:8], 8'($urandom));
        send_plain(ACT_WRITE, pc_reg + 12'd1, ins[7:0], 8'($urandom));
        send_plain(ACT_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
        k += 3;
      end else begin
        send_plain(3'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
        k++;
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("chip8_instruction_core_tb passed");
    end else begin
      $display("chip8_instruction_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/c8ic_pkg.sv
rtl/c8ic_mem.sv
rtl/chip8_instruction_core.sv
tb/sv/chip8_instruction_core_tb.sv
